### rtl/gbb_pkg.sv
// Shared types and constants for the grayscale blend blitter.
// Depends on nothing; every RTL file but gbb_frame_ram refers to it by scoped names.
`default_nettype none

package gbb_pkg;

    // Frame store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // Field widths
    localparam int PIX_W       = 8;
    localparam int POS_W       = 8;
    localparam int DIM_W       = 9;
    localparam int OFFSET_W    = 9;
    localparam int ALPHA_W     = 8;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    // signed coordinate after offset: -256 .. 510
    localparam int COORD_W     = POS_W + 2;
    localparam int PROD_W      = ALPHA_W + PIX_W;

    typedef enum logic [0:0] {
        CMD_BLEND = 1'b0,
        CMD_READ  = 1'b1
    } command_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_REPLACE = 2'd0,
        MODE_ADD     = 2'd1,
        MODE_SUB     = 2'd2,
        MODE_ALPHA   = 2'd3
    } blend_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_BLEND_MODE   = 3'd2,
        CFG_BLEND_ALPHA  = 3'd3,
        CFG_OFFSET_X     = 3'd4,
        CFG_OFFSET_Y     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        command_t           command;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [PIX_W-1:0]   src_pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic               in_frame;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/gbb_frame_ram.sv
// Generic single-write, single-read synchronous RAM holding the frame.
// Read data is registered. No package dependency.
`default_nettype none

module gbb_frame_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/gray_blend_blitter_unit.sv
// Top level of the grayscale blend blitter: configuration registers, item
// sequencer, blend datapath and output register. Uses gbb_pkg, gbb_frame_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_ready   | in_item  (gbb_pkg::in_item_t)
//  out     | output    | out_valid / out_ready | out_item (gbb_pkg::out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction at a time: accept, frame read, then blend and write-back,
// each in its own sequencer state (idle, lookup, update).
// The read-modify-write on the single frame RAM keeps it to one at a time.
// The output register lets the next transaction in while a result waits;
// a full output register holds the sequencer in its write-back step.
// Reset (rst_n, asynchronous, active low) restores the register defaults;
// the frame contents are not cleared and must be written before being read.
`default_nettype none

module gray_blend_blitter_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire gbb_pkg::in_item_t                     in_item,

    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output gbb_pkg::out_item_t                         out_item,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [gbb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [gbb_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gbb_pkg::DIM_W-1:0]    frame_width_reg;
    logic [gbb_pkg::DIM_W-1:0]    frame_height_reg;
    gbb_pkg::blend_mode_t         blend_mode_reg;
    logic [gbb_pkg::ALPHA_W-1:0]  blend_alpha_reg;
    logic [gbb_pkg::OFFSET_W-1:0] offset_x_reg;
    logic [gbb_pkg::OFFSET_W-1:0] offset_y_reg;

    // Always ready: writes are to arrive only while the block is idle; the block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= gbb_pkg::DIM_W'(256);
            frame_height_reg <= gbb_pkg::DIM_W'(256);
            blend_mode_reg   <= gbb_pkg::MODE_REPLACE;
            blend_alpha_reg  <= gbb_pkg::ALPHA_W'(255);
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gbb_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[gbb_pkg::DIM_W-1:0];
                gbb_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[gbb_pkg::DIM_W-1:0];
                gbb_pkg::CFG_BLEND_MODE:
                    blend_mode_reg <= gbb_pkg::blend_mode_t'(cfg_data[gbb_pkg::MODE_W-1:0]);
                gbb_pkg::CFG_BLEND_ALPHA:  blend_alpha_reg  <= cfg_data[gbb_pkg::ALPHA_W-1:0];
                gbb_pkg::CFG_OFFSET_X:     offset_x_reg     <= cfg_data[gbb_pkg::OFFSET_W-1:0];
                gbb_pkg::CFG_OFFSET_Y:     offset_y_reg     <= cfg_data[gbb_pkg::OFFSET_W-1:0];
                default:                   ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Destination coordinate and frame check, at acceptance
    // ------------------------------------------------------------------
    logic                                 in_fire;
    logic [gbb_pkg::OFFSET_W-1:0]         add_x;
    logic [gbb_pkg::OFFSET_W-1:0]         add_y;
    logic signed [gbb_pkg::COORD_W-1:0]   dst_x;
    logic signed [gbb_pkg::COORD_W-1:0]   dst_y;
    logic signed [gbb_pkg::COORD_W-1:0]   lim_x;
    logic signed [gbb_pkg::COORD_W-1:0]   lim_y;
    logic                                 hit;
    logic [gbb_pkg::ADDR_W-1:0]           dst_addr;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        // reads address the frame directly, with no offset
        add_x = (in_item.command == gbb_pkg::CMD_BLEND) ? offset_x_reg : '0;
        add_y = (in_item.command == gbb_pkg::CMD_BLEND) ? offset_y_reg : '0;

        dst_x = $signed({{(gbb_pkg::COORD_W-gbb_pkg::POS_W){1'b0}}, in_item.pos_x})
              + $signed({{(gbb_pkg::COORD_W-gbb_pkg::OFFSET_W){add_x[gbb_pkg::OFFSET_W-1]}},
                         add_x});
        dst_y = $signed({{(gbb_pkg::COORD_W-gbb_pkg::POS_W){1'b0}}, in_item.pos_y})
              + $signed({{(gbb_pkg::COORD_W-gbb_pkg::OFFSET_W){add_y[gbb_pkg::OFFSET_W-1]}},
                         add_y});

        lim_x = $signed({{(gbb_pkg::COORD_W-gbb_pkg::DIM_W){1'b0}}, frame_width_reg});
        lim_y = $signed({{(gbb_pkg::COORD_W-gbb_pkg::DIM_W){1'b0}}, frame_height_reg});

        // frame size above the store size acts as the store size
        hit = (dst_x >= 0) && (dst_x < lim_x) && (int'(dst_x) < gbb_pkg::MAX_WIDTH)
           && (dst_y >= 0) && (dst_y < lim_y) && (int'(dst_y) < gbb_pkg::MAX_HEIGHT);

        // row-major index; only meaningful when hit is set
        dst_addr = gbb_pkg::ADDR_W'(dst_y) * gbb_pkg::ADDR_W'(gbb_pkg::MAX_WIDTH)
                 + gbb_pkg::ADDR_W'(dst_x);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    gbb_pkg::state_t state_reg;
    gbb_pkg::state_t state_next;
    logic            out_free;
    logic            rd_en;
    logic            finish;

    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gbb_pkg::ST_LOOKUP;
                end
            end
            gbb_pkg::ST_LOOKUP:
            begin
                state_next = gbb_pkg::ST_UPDATE;
            end
            gbb_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = gbb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            gbb_pkg::ST_IDLE:   in_ready = 1'b1;
            gbb_pkg::ST_LOOKUP: rd_en    = 1'b1;
            gbb_pkg::ST_UPDATE: finish   = out_free;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Transaction registers (payload, no reset)
    // ------------------------------------------------------------------
    logic                          is_blend_reg;
    logic                          hit_reg;
    logic [gbb_pkg::ADDR_W-1:0]    addr_reg;
    logic [gbb_pkg::PIX_W-1:0]     src_reg;
    logic [gbb_pkg::PROD_W-1:0]    prod_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            is_blend_reg <= (in_item.command == gbb_pkg::CMD_BLEND);
            hit_reg      <= hit;
            addr_reg     <= dst_addr;
            src_reg      <= in_item.src_pixel;
        end
        if (rd_en)
        begin
            // alpha product registered ahead of the divide by 255
            prod_reg <= gbb_pkg::PROD_W'(blend_alpha_reg) * gbb_pkg::PROD_W'(src_reg);
        end
    end

    // ------------------------------------------------------------------
    // Frame store
    // ------------------------------------------------------------------
    logic [gbb_pkg::PIX_W-1:0] frame_rd_data;
    logic                      wr_en;
    logic [gbb_pkg::PIX_W-1:0] blend_val;

    // Reads and writes of one transaction are sequenced; the next read is
    // issued only after the write-back, so no forwarding path is needed.
    assign wr_en = finish && hit_reg && is_blend_reg;

    gbb_frame_ram #(
        .ADDR_W (gbb_pkg::ADDR_W),
        .DATA_W (gbb_pkg::PIX_W)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (blend_val),
        .rd_en   (rd_en && hit_reg),
        .rd_addr (addr_reg),
        .rd_data (frame_rd_data)
    );

    // ------------------------------------------------------------------
    // Blend datapath
    // ------------------------------------------------------------------
    logic [gbb_pkg::PIX_W:0]    sum_add;
    logic [gbb_pkg::PROD_W:0]   div_tmp;
    logic [gbb_pkg::PIX_W-1:0]  quot;
    logic [gbb_pkg::PIX_W-1:0]  scaled;
    logic [gbb_pkg::PIX_W:0]    sum_alpha;

    always_comb
    begin
        sum_add = {1'b0, frame_rd_data} + {1'b0, src_reg};

        // floor(n / 255) = (n + 1 + (n >> 8)) >> 8 for any n below 2^16 - 1
        div_tmp = {1'b0, prod_reg} + (gbb_pkg::PROD_W+1)'(1)
                + (gbb_pkg::PROD_W+1)'(prod_reg >> 8);
        quot    = div_tmp[gbb_pkg::PIX_W +: gbb_pkg::PIX_W];
        scaled  = quot >> 2;
        sum_alpha = {1'b0, frame_rd_data} + {1'b0, scaled};

        unique case (blend_mode_reg)
            gbb_pkg::MODE_REPLACE:
                blend_val = src_reg;
            gbb_pkg::MODE_ADD:
                blend_val = sum_add[gbb_pkg::PIX_W] ? '1 : sum_add[gbb_pkg::PIX_W-1:0];
            gbb_pkg::MODE_SUB:
                blend_val = (frame_rd_data > src_reg) ? frame_rd_data - src_reg : '0;
            gbb_pkg::MODE_ALPHA:
                blend_val = sum_alpha[gbb_pkg::PIX_W] ? '1 : sum_alpha[gbb_pkg::PIX_W-1:0];
            default:
                blend_val = src_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                  out_valid_reg;
    gbb_pkg::out_item_t    out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_item_reg.in_frame  <= hit_reg;
            out_item_reg.pixel_out <= !hit_reg     ? '0
                                    : is_blend_reg ? blend_val
                                    :                frame_rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

### rtl/gbb_checker.sv
// Port-level checker for gray_blend_blitter_unit, with its bind statement.
// Depends on gbb_pkg for the payload types.
`default_nettype none

module gbb_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire gbb_pkg::out_item_t                    out_item
);

    // one transaction in flight: after an item is taken, in_ready stays low through the lookup and write-back steps
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a transaction is in flight");

    // a fresh result only follows the write-back step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a completed transaction");

    // an out-of-frame result carries a zero pixel
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.in_frame) |-> (out_item.pixel_out == '0))
        else $error("out-of-frame result with non-zero pixel");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed or dropped");

endmodule

bind gray_blend_blitter_unit gbb_checker u_gbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire

### verif/gray_blend_blitter_unit_tb.sv
// Self-checking testbench for gray_blend_blitter_unit: a directed table, then random
// pixel traffic under changing frame settings, checked against a behavioural frame copy.
// Depends on gbb_pkg and the gray_blend_blitter_unit RTL only.
module gray_blend_blitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbb_pkg::*;

    // Register indexes beyond the defined set: writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT   = 3000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 12;    // sequencer settle time plus margin
    localparam int N_PLAN        = 43;
    localparam int N_SETTINGS    = 24;
    localparam int REPORT_MAX    = 10;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    in_item_t                     in_item = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    out_item_t                    out_item;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    gray_blend_blitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register file, frame contents, and which
    // pixels have been written at least once (the rest must never be read).
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]           cur_width  = 9'd256;
    logic [DIM_W-1:0]           cur_height = 9'd256;
    blend_mode_t                cur_mode   = MODE_REPLACE;
    logic [ALPHA_W-1:0]         cur_alpha  = 8'd255;
    logic signed [OFFSET_W-1:0] cur_offx   = '0;
    logic signed [OFFSET_W-1:0] cur_offy   = '0;

    logic [PIX_W-1:0]           frame_copy  [MAX_WIDTH*MAX_HEIGHT];
    bit                         pix_written [MAX_WIDTH*MAX_HEIGHT];
    int unsigned                written_list[$];

    out_item_t                  expected_pixels[$];

    // Corner of a small window that random blends hammer, so that
    // back-to-back read-modify-writes hit the same few addresses
    int hot_x, hot_y;

    int send_idle_pct, recv_stall_pct;
    int fail_count, results_seen, blends_sent, reads_sent, hits_sent, reg_writes;

    // One row of the directed table: either a register write or a pixel
    // transaction, the latter optionally carrying a hand-worked result
    typedef struct {
        bit                       is_write;
        logic [CFG_INDEX_W-1:0]   reg_sel;
        logic [CFG_DATA_W-1:0]    reg_value;
        in_item_t                 item;
        bit                       has_known;
        out_item_t                known;
    } step_t;

    step_t plan [N_PLAN];

    function automatic step_t reg_row(logic [CFG_INDEX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
        step_t s;
        s = '{default: '0};
        s.is_write  = 1'b1;
        s.reg_sel   = sel;
        s.reg_value = value;
        return s;
    endfunction

    function automatic step_t pix_row(command_t cmd, logic [7:0] x, logic [7:0] y,
                                      logic [7:0] p, bit has_known,
                                      logic [7:0] k_pix, logic k_in);
        step_t s;
        s = '{default: '0};
        s.item.command   = cmd;
        s.item.pos_x     = x;
        s.item.pos_y     = y;
        s.item.src_pixel = p;
        s.has_known      = has_known;
        s.known.pixel_out = k_pix;
        s.known.in_frame  = k_in;
        return s;
    endfunction

    function automatic int eff_dim(logic [DIM_W-1:0] v, int limit);
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // Destination address of a transaction, or -1 when it falls outside the
    // frame. Reads address the frame directly; blends go through the offset.
    function automatic int frame_index(in_item_t it);
        int x, y;
        x = it.pos_x;
        y = it.pos_y;
        if (it.command == CMD_BLEND)
        begin
            x += cur_offx;
            y += cur_offy;
        end
        if (x < 0 || y < 0 || x >= eff_dim(cur_width, MAX_WIDTH) ||
            y >= eff_dim(cur_height, MAX_HEIGHT))
            return -1;
        return y * MAX_WIDTH + x;
    endfunction

    // Work out the result of one accepted transaction and advance the frame copy
    function automatic out_item_t predict_pixel(in_item_t it);
        int idx, f, p, v;
        out_item_t r;
        idx = frame_index(it);
        r = '0;
        if (idx < 0)
            return r;
        f = frame_copy[idx];
        p = it.src_pixel;
        if (it.command == CMD_READ)
            v = f;
        else
        begin
            case (cur_mode)
                MODE_REPLACE: v = p;
                MODE_ADD:     v = (f + p > 255) ? 255 : f + p;
                MODE_SUB:     v = (f > p) ? f - p : 0;
                default:
                begin
                    v = f + (int'(cur_alpha) * p / 255) / 4;
                    if (v > 255)
                        v = 255;
                end
            endcase
            frame_copy[idx] = 8'(v);
            if (!pix_written[idx])
            begin
                pix_written[idx] = 1'b1;
                written_list.push_back(idx);
            end
        end
        r.pixel_out = 8'(v);
        r.in_frame  = 1'b1;
        return r;
    endfunction

    // A transaction may touch an unwritten pixel only when it overwrites it
    function automatic bit item_is_legal(in_item_t it);
        int idx;
        idx = frame_index(it);
        return idx < 0 || (it.command == CMD_BLEND && cur_mode == MODE_REPLACE) ||
               pix_written[idx];
    endfunction

    // Random transaction: mostly blends and reads aimed at written pixels or at
    // the hot window, the rest anywhere. Candidates that would touch an
    // unwritten pixel are thrown away and another is drawn.
    function automatic in_item_t pick_item();
        in_item_t    it;
        int unsigned n, k, sel;
        int          dx, dy;
        for (int tries = 0; tries < 16; tries++)
        begin
            it = $bits(in_item_t)'($urandom);
            it.command = CMD_BLEND;
            sel = $urandom_range(99);
            n = written_list.size();
            dx = -1;
            dy = -1;
            if (sel < 55 && n > 0)
            begin
                if (n > 12 && $urandom_range(99) < 70)
                    k = $urandom_range(n - 1, n - 12);
                else
                    k = $urandom_range(n - 1, 0);
                dx = written_list[k] % MAX_WIDTH;
                dy = written_list[k] / MAX_WIDTH;
            end
            else if (sel < 80)
            begin
                dx = hot_x + $urandom_range(5);
                dy = hot_y + $urandom_range(5);
            end
            else if (sel < 86)
                it.command = CMD_READ;

            if (sel < 18 && n > 0)
            begin
                it.command = CMD_READ;
                it.pos_x   = 8'(dx);
                it.pos_y   = 8'(dy);
            end
            else if (dx >= 0)
            begin
                // back out the offset to find the source coordinate
                dx -= cur_offx;
                dy -= cur_offy;
                if (dx < 0 || dx > 255 || dy < 0 || dy > 255)
                    continue;
                it.pos_x = 8'(dx);
                it.pos_y = 8'(dy);
            end
            if (item_is_legal(it))
                return it;
        end
        // a read of a written address is always allowed, in frame or not
        it = '0;
        it.command = CMD_READ;
        it.pos_x   = 8'(written_list[0] % MAX_WIDTH);
        it.pos_y   = 8'(written_list[0] / MAX_WIDTH);
        return it;
    endfunction

    // Anchor of the hot window along one axis, inside what blends can reach
    function automatic int pick_anchor(int offset, int extent);
        int lo, hi;
        lo = (offset > 0) ? offset : 0;
        hi = offset + 255;
        if (hi > extent - 1)
            hi = extent - 1;
        return (lo <= hi) ? $urandom_range(hi, lo) : 0;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return '0;
            1, 2:    return 9'($urandom_range(511, 257));
            3, 4:    return 9'd256;
            5:       return 9'd1;
            default: return 9'($urandom_range(256, 1));
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_offset();
        case ($urandom_range(9))
            0, 1:    return 9'($urandom);
            2:       return 9'h100;
            3:       return 9'h0FF;
            default: return 9'(int'($urandom_range(48)) - 24);
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(6))
            0:       return '0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Hold the register write until it is taken, then mirror it in the shadow
    task automatic write_reg(logic [CFG_INDEX_W-1:0] sel, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (sel)
            CFG_FRAME_WIDTH:  cur_width  = value;
            CFG_FRAME_HEIGHT: cur_height = value;
            CFG_BLEND_MODE:   cur_mode   = blend_mode_t'(value[MODE_W-1:0]);
            CFG_BLEND_ALPHA:  cur_alpha  = value[ALPHA_W-1:0];
            CFG_OFFSET_X:     cur_offx   = value;
            CFG_OFFSET_Y:     cur_offy   = value;
            default:          ;
        endcase
        reg_writes++;
    endtask

    // Offer one pixel transaction, after an optional random gap, and queue
    // its expected result once it is accepted
    task automatic send_pixel(in_item_t it, bit has_known, out_item_t known);
        out_item_t guess;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        guess = predict_pixel(it);
        expected_pixels.push_back(has_known ? known : guess);
        if (it.command == CMD_READ)
            reads_sent++;
        else
            blends_sent++;
        if (guess.in_frame)
            hits_sent++;
    endtask

    // Drop the input valid and hold until every queued result has come back
    task automatic drain_results();
        if (in_valid || expected_pixels.size() != 0)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (expected_pixels.size() != 0);
        end
    endtask

    task automatic send_burst(int count);
        int pause_at;
        pause_at = $urandom_range(count - 1);
        for (int i = 0; i < count; i++)
        begin
            // now and then let the pipeline run dry in the middle of a burst
            if (i == pause_at && $urandom_range(1) == 1)
                drain_results();
            send_pixel(pick_item(), 1'b0, '0);
        end
    endtask

    // One random setting: new geometry, offsets and alpha, seed the hot window
    // in replace mode, then switch to a random mode and run the main burst
    task automatic run_setting(int seeds, int mains);
        drain_results();
        write_reg(CFG_FRAME_WIDTH,  pick_dim());
        write_reg(CFG_FRAME_HEIGHT, pick_dim());
        write_reg(CFG_OFFSET_X,     pick_offset());
        write_reg(CFG_OFFSET_Y,     pick_offset());
        write_reg(CFG_BLEND_ALPHA,  {1'($urandom), pick_alpha()});
        write_reg(CFG_BLEND_MODE,   {7'($urandom), 2'(MODE_REPLACE)});
        hot_x = pick_anchor(cur_offx, eff_dim(cur_width, MAX_WIDTH));
        hot_y = pick_anchor(cur_offy, eff_dim(cur_height, MAX_HEIGHT));
        send_burst(seeds);
        drain_results();
        write_reg(CFG_BLEND_MODE, 9'($urandom));
        send_burst(mains);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare against the oldest
    // expectation. Report the first few failures, count the rest.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("%0t: unexpected result pixel_out=%0d in_frame=%0b", $realtime,
                             out_item.pixel_out, out_item.in_frame);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_item.pixel_out !== want.pixel_out ||
                    out_item.in_frame !== want.in_frame)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"%0t: mismatch, expected pixel_out=%0d in_frame=%0b,",
                                  " got pixel_out=%0d in_frame=%0b"},
                                 $realtime, want.pixel_out, want.in_frame,
                                 out_item.pixel_out, out_item.in_frame);
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d cycles without a transaction", quiet);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        plan = '{
            // after reset: full frame, replace, no offset; corners and both extremes
            pix_row(CMD_BLEND,   8'd0,   8'd0,   8'd0,   1, 8'd0,   1'b1),
            pix_row(CMD_BLEND, 8'd255, 8'd255, 8'd255,   1, 8'd255, 1'b1),
            pix_row(CMD_READ,  8'd255, 8'd255,   8'd0,   1, 8'd255, 1'b1),
            pix_row(CMD_BLEND, 8'd255,   8'd0, 8'hAA,    1, 8'hAA,  1'b1),
            pix_row(CMD_BLEND,   8'd0, 8'd255, 8'h55,    1, 8'h55,  1'b1),
            pix_row(CMD_READ,    8'd0,   8'd0, 8'hFF,    1, 8'd0,   1'b1),
            // saturating add: clip at the top, then an ordinary sum
            reg_row(CFG_BLEND_MODE, 9'(MODE_ADD)),
            pix_row(CMD_BLEND, 8'd255, 8'd255,   8'd1,   1, 8'd255, 1'b1),
            pix_row(CMD_BLEND,   8'd0, 8'd255, 8'h80,    0, 8'd0,   1'b0),
            // saturating subtract: clip at zero, then an ordinary difference
            reg_row(CFG_BLEND_MODE, 9'(MODE_SUB)),
            pix_row(CMD_BLEND,   8'd0,   8'd0,   8'd1,   1, 8'd0,   1'b1),
            pix_row(CMD_BLEND, 8'd255,   8'd0, 8'h0A,    0, 8'd0,   1'b0),
            // scaled alpha add at full alpha, then at zero alpha
            reg_row(CFG_BLEND_MODE, 9'(MODE_ALPHA)),
            pix_row(CMD_BLEND,   8'd0,   8'd0, 8'd255,   0, 8'd0,   1'b0),
            pix_row(CMD_BLEND, 8'd255, 8'd255, 8'd255,   1, 8'd255, 1'b1),
            reg_row(CFG_BLEND_ALPHA, 9'd0),
            pix_row(CMD_BLEND,   8'd0, 8'd255, 8'd255,   0, 8'd0,   1'b0),
            // writes to undefined register indexes must leave everything alone
            reg_row(CFG_SPARE_LO, 9'h1FF),
            reg_row(CFG_SPARE_HI, 9'h1FF),
            pix_row(CMD_READ,    8'd0, 8'd255,   8'd0,   0, 8'd0,   1'b0),
            // extreme offsets: the blend lands above the frame
            reg_row(CFG_OFFSET_X, 9'h0FF),
            reg_row(CFG_OFFSET_Y, 9'h100),
            pix_row(CMD_BLEND,   8'd0, 8'd255, 8'h33,    1, 8'd0,   1'b0),
            // large negative x offset pulls a far source back to column zero
            reg_row(CFG_OFFSET_X, 9'h101),
            reg_row(CFG_OFFSET_Y, 9'h0FF),
            pix_row(CMD_BLEND, 8'd255,   8'd0, 8'h44,    0, 8'd0,   1'b0),
            // reads ignore the offset
            pix_row(CMD_READ,    8'd0,   8'd0,   8'd0,   0, 8'd0,   1'b0),
            reg_row(CFG_OFFSET_X, 9'd0),
            reg_row(CFG_OFFSET_Y, 9'd0),
            // zero width puts every pixel out of frame
            reg_row(CFG_FRAME_WIDTH, 9'd0),
            pix_row(CMD_BLEND,   8'd0,   8'd0, 8'h11,    1, 8'd0,   1'b0),
            // oversized width acts as the maximum; zero height still rejects
            reg_row(CFG_FRAME_WIDTH, 9'h1FF),
            reg_row(CFG_FRAME_HEIGHT, 9'd0),
            pix_row(CMD_READ,    8'd0,   8'd0,   8'd0,   1, 8'd0,   1'b0),
            // one column wide, oversized height
            reg_row(CFG_FRAME_HEIGHT, 9'd257),
            reg_row(CFG_FRAME_WIDTH, 9'd1),
            pix_row(CMD_READ,    8'd0, 8'd255,   8'd0,   0, 8'd0,   1'b0),
            pix_row(CMD_READ,    8'd1,   8'd0,   8'd0,   1, 8'd0,   1'b0),
            // both sizes oversized, back to replace at the far corner
            reg_row(CFG_FRAME_WIDTH, 9'h1FF),
            reg_row(CFG_FRAME_HEIGHT, 9'h1FF),
            reg_row(CFG_BLEND_MODE, 9'(MODE_REPLACE)),
            pix_row(CMD_BLEND, 8'd255, 8'd255, 8'h5A,    1, 8'h5A,  1'b1),
            pix_row(CMD_READ,  8'd255, 8'd255,   8'd0,   1, 8'h5A,  1'b1)
        };

        send_idle_pct  = 23;
        recv_stall_pct = 57;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table; register writes only with the block idle
        for (int i = 0; i < N_PLAN; i++)
        begin
            if (plan[i].is_write)
            begin
                drain_results();
                write_reg(plan[i].reg_sel, plan[i].reg_value);
            end
            else
                send_pixel(plan[i].item, plan[i].has_known, plan[i].known);
        end

        // random settings: busy receiver, then busy sender, then full rate
        for (int s = 0; s < N_SETTINGS; s++)
        begin
            if (s == N_SETTINGS / 3)
            begin
                send_idle_pct  = 57;
                recv_stall_pct = 23;
            end
            if (s == 2 * N_SETTINGS / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            run_setting(15, 62);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += expected_pixels.size();

        $display("Pixel traffic: %0d blends, %0d reads, %0d inside the frame,",
                 blends_sent, reads_sent, hits_sent);
        $display("  %0d results compared; register writes: %0d over %0d random frame settings",
                 results_seen, reg_writes, N_SETTINGS);
        $display("Failures: %0d", fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
